### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for stream find and replace
// Register indexes, field widths and the burst descriptor passed from the
// classifier to the output serializer.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int MAX_PATTERN_DEF     = 8;
   localparam int MAX_REPLACEMENT_DEF = 8;

   localparam int BYTE_W      = 8;
   localparam int WIN_DEPTH   = 8;
   localparam int WIN_IDX_W   = 3;
   localparam int LEN_W       = 4;
   localparam int CFG_DATA_W  = 64;
   localparam int CSR_INDEX_W = 4;
   localparam int COUNT_W     = 32;
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 4'd3;

   typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] window_type;

   // one burst of result bytes caused by one request
   typedef struct packed {
      window_type         bytes;
      logic [LEN_W-1:0]   n;       // bytes in the burst, 1..8
      logic               marker;  // bare end marker, no data
      logic               last;    // burst closes the text
      logic [COUNT_W-1:0] count;   // match count, used on the final byte
   } desc_type;

endpackage

### rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_valid;
   logic        out_last;
   logic [31:0] match_count;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output match_count, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   input match_count, output ready);
endinterface

interface csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: request intake and classification
// Holds the configuration and the window of undecided bytes, compares the
// window with the pattern and turns each request into at most one burst.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
   parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   req_if.sink      req_ch,
   csr_if.sink      csr_ch,
   input  logic     queue_full,
   output logic     push_valid,
   output desc_type push_desc
);

   localparam int PAT_W  = MAX_PATTERN * BYTE_W;
   localparam int REPL_W = MAX_REPLACEMENT * BYTE_W;

   logic [PAT_W-1:0]   pat_ff;
   logic [LEN_W-1:0]   pat_len_ff;
   logic [REPL_W-1:0]  repl_ff;
   logic [LEN_W-1:0]   repl_len_ff;
   window_type         win_ff, win_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   logic                 accept;
   logic [LEN_W-1:0]     plen, rlen, f1;
   logic [WIN_IDX_W-1:0] f0;
   window_type           win_w, repl_win;
   logic [COUNT_W-1:0]   cnt_inc;
   logic                 hit;

   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff      <= '0;
         pat_len_ff  <= '0;
         repl_ff     <= '0;
         repl_len_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_PATTERN_BYTES:      pat_ff      <= csr_ch.data[PAT_W-1:0];
            CSR_PATTERN_LENGTH:     pat_len_ff  <= csr_ch.data[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  repl_ff     <= csr_ch.data[REPL_W-1:0];
            CSR_REPLACEMENT_LENGTH: repl_len_ff <= csr_ch.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      plen = (pat_len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_ff;
      rlen = (repl_len_ff > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT)
                                                      : repl_len_ff;
      repl_win = window_type'(CFG_DATA_W'(repl_ff));

      // a full window overwrites its newest entry
      f0 = (fill_ff >= LEN_W'(WIN_DEPTH)) ? WIN_IDX_W'(WIN_DEPTH - 1) : fill_ff[WIN_IDX_W-1:0];
      win_w     = win_ff;
      win_w[f0] = req_ch.in_byte;
      f1        = LEN_W'(f0) + LEN_W'(1);

      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (LEN_W'(i) < plen && win_w[i] != pat_ff[i*BYTE_W +: BYTE_W])
            hit = 1'b0;
      end

      cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_W'(1);

      fill_in    = fill_ff;
      win_in     = win_ff;
      cnt_in     = cnt_ff;
      push_valid = 1'b0;
      push_desc  = '0;

      if (accept) begin
         win_in  = win_w;
         fill_in = f1;
         if (req_ch.in_last) begin
            push_valid     = 1'b1;
            push_desc.last = 1'b1;
            fill_in        = '0;
            cnt_in         = '0;
            if (plen != '0 && f1 == plen && hit) begin
               push_desc.bytes = repl_win;
               push_desc.n     = rlen;
               push_desc.count = cnt_inc;
            end else begin
               push_desc.bytes = win_w;
               push_desc.n     = f1;
               push_desc.count = cnt_ff;
            end
            // nothing to emit: close the text with a bare marker
            if (push_desc.n == '0) begin
               push_desc.n      = LEN_W'(1);
               push_desc.marker = 1'b1;
               push_desc.bytes  = '0;
            end
         end else if (plen == '0) begin
            push_valid      = 1'b1;
            push_desc.bytes = win_w;
            push_desc.n     = f1;
            fill_in         = '0;
         end else if (f1 >= plen) begin
            if (hit) begin
               cnt_in  = cnt_inc;
               win_in  = win_w >> {plen, 3'b000};
               fill_in = f1 - plen;
               if (rlen != '0) begin
                  push_valid      = 1'b1;
                  push_desc.bytes = repl_win;
                  push_desc.n     = rlen;
               end
            end else begin
               // release the oldest byte
               push_valid      = 1'b1;
               push_desc.bytes = win_w;
               push_desc.n     = LEN_W'(1);
               win_in          = win_w >> BYTE_W;
               fill_in         = f1 - LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

### rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue: burst descriptor queue
// Small first-in first-out buffer between the classifier and the serializer.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head_desc
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push_valid)
         mem_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_valid)
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push_valid && !pop)
            cnt_ff <= cnt_ff + CNT_W'(1);
         else if (pop && !push_valid)
            cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

endmodule

### rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: output serializer
// Walks the burst at the head of the queue one byte per cycle, while rsp_ch
// is ready, into the response register.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head_desc,
   output logic     pop,
   rsp_if.source    rsp_ch
);

   logic [WIN_IDX_W-1:0] idx_ff;
   logic                 valid_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 data_ff, last_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 load, burst_end;

   assign load      = head_valid && (!valid_ff || rsp_ch.ready);
   assign burst_end = (LEN_W'(idx_ff) + LEN_W'(1)) == head_desc.n;
   assign pop       = load && burst_end;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.out_valid   = data_ff;
   assign rsp_ch.out_last    = last_ff;
   assign rsp_ch.match_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load)
            valid_ff <= 1'b1;
         else if (rsp_ch.ready)
            valid_ff <= 1'b0;
         if (pop)
            idx_ff <= '0;
         else if (load)
            idx_ff <= idx_ff + WIN_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= head_desc.bytes[idx_ff];
         data_ff  <= !head_desc.marker;
         last_ff  <= head_desc.last && burst_end;
         count_ff <= (head_desc.last && burst_end) ? head_desc.count : '0;
      end
   end

endmodule

### rtl/stream_find_replace_all.sv
// ----------------------------------------------------------------------------
// stream_find_replace_all: streaming find and replace of a byte pattern
// Rewrites a text stream, replacing every leftmost non-overlapping occurrence
// of the pattern with the replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  one source byte per request, in_last on the final byte of a text.
//   rsp_ch  one rewritten byte per response; out_last and match_count on the
//           final response of a text, out_valid low on a bare end marker.
//   csr_ch  register writes (pattern, its length, replacement, its length),
//           always ready; write only while no text is in flight.
// A request is classified in the cycle it is accepted and queued as a burst
// of 0 to 8 response bytes, which pass the queue and the response register.
// Requests are taken one per cycle while the four-entry burst queue has room;
// the serializer emits one byte per cycle while rsp_ch is ready, so long
// replacements and final flushes hold the input back once the queue fills.
// A stalled rsp_ch fills the queue and then drops req_ch.ready.
// Reset empties window and queue, clears match count, configuration and rsp valid.
// ----------------------------------------------------------------------------
module stream_find_replace_all import sfr_pkg::*; #(
   parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
   input  logic  clock,
   input  logic  reset,
   req_if.sink   req_ch,
   rsp_if.source rsp_ch,
   csr_if.sink   csr_ch
);

   logic     push_valid, queue_full, pop, head_valid;
   desc_type push_desc, head_desc;

   sfr_front #(
      .MAX_PATTERN     (MAX_PATTERN),
      .MAX_REPLACEMENT (MAX_REPLACEMENT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_desc  (push_desc)
   );

   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
